@@ hdl/uart_ring_buffer_pair_assert.svh @@
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair assertion macros
// Shared property forms for the ring buffer pair checks.
// ----------------------------------------------------------------------------
`ifndef UART_RING_BUFFER_PAIR_ASSERT_SVH
`define UART_RING_BUFFER_PAIR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define URBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define URBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked through reset
`define URBP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/urbp_pkg.sv @@
// ----------------------------------------------------------------------------
// urbp_pkg
// Operation, status and counter codes and the ring status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package urbp_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TX_FULL = 2'd1;
    localparam logic [1:0] ST_RX_EMPTY = 2'd2;

    localparam int NUM_COUNTS = 6;
    localparam logic [2:0] CNT_HW_OVR  = 3'd0;
    localparam logic [2:0] CNT_NOISE   = 3'd1;
    localparam logic [2:0] CNT_FRAME   = 3'd2;
    localparam logic [2:0] CNT_PARITY  = 3'd3;
    localparam logic [2:0] CNT_TX_FULL = 3'd4;
    localparam logic [2:0] CNT_RX_FULL = 3'd5;

    typedef struct packed {
        logic full;
        logic empty;
    } ring_stat_t;

endpackage

`default_nettype wire

@@ hdl/urbp_ring.sv @@
// ----------------------------------------------------------------------------
// urbp_ring
// Byte ring in a synchronous memory with head and tail pointers; one slot
// stays free so that full and empty differ. Pop data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module urbp_ring #(
    parameter int DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push_en,
    input  wire logic [7:0]            push_data,
    input  wire logic                  pop_en,
    output logic [7:0]                 pop_data,
    output urbp_pkg::ring_stat_t       stat
);
    import urbp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    mem [DEPTH];
    logic [PW-1:0] head_reg;
    logic [PW-1:0] tail_reg;
    logic [PW-1:0] head_next;
    logic [PW-1:0] tail_next;
    logic [7:0]    rd_data_reg;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        n = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return n;
    endfunction

    assign head_next  = advance(head_reg);
    assign tail_next  = advance(tail_reg);
    assign stat.full  = (tail_next == head_reg);
    assign stat.empty = (head_reg == tail_reg);
    assign pop_data   = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            if (push_en) begin
                tail_reg <= tail_next;
            end
            if (pop_en) begin
                head_reg <= head_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[tail_reg] <= push_data;
        end
        if (pop_en) begin
            rd_data_reg <= mem[head_reg];
        end
    end

endmodule

`default_nettype wire

@@ hdl/uart_ring_buffer_pair.sv @@
// ----------------------------------------------------------------------------
// uart_ring_buffer_pair
// Buffered serial port: transmit and receive byte rings and six error
// counters behind one request channel.
// ----------------------------------------------------------------------------
// Each request is taken into the pending stage, and its result moves on to
// the output register once that is free; with the result side ready, one
// request per clock is sustained. The pending stage waits on the registered
// read port of the ring memories, which supplies the popped byte for get
// and for a uart event. A new request is taken while a finished result
// waits, as long as the single pending stage can move on.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_ring_buffer_pair #(
    parameter int TX_DEPTH   = 64,
    parameter int RX_DEPTH   = 64,
    parameter int COUNT_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [7:0]  s_char_in,
    input  wire logic        s_rx_valid,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_tx_ready,
    input  wire logic        s_overrun_flag,
    input  wire logic        s_noise_flag,
    input  wire logic        s_frame_flag,
    input  wire logic        s_parity_flag,
    input  wire logic [2:0]  s_counter_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_char_out,
    output logic             m_char_valid,
    output logic             m_send_valid,
    output logic [7:0]       m_send_byte,
    output logic             m_tx_irq_enabled,
    output logic [31:0]      m_counter_value
);
    import urbp_pkg::*;

    ring_stat_t tx_stat;
    ring_stat_t rx_stat;
    logic [7:0] tx_pop_data;
    logic [7:0] rx_pop_data;

    logic accept;
    logic out_free;
    logic tx_push;
    logic tx_pop;
    logic rx_push;
    logic rx_pop;
    logic [NUM_COUNTS-1:0] bump;
    logic [1:0]  status_next;
    logic        irq_next;
    logic [31:0] count_next;

    logic [COUNT_BITS-1:0] cnt_reg [NUM_COUNTS];
    logic        irq_reg;
    logic        pend_reg;
    logic [1:0]  pend_status_reg;
    logic        pend_char_valid_reg;
    logic        pend_send_valid_reg;
    logic        pend_irq_reg;
    logic [31:0] pend_count_reg;

    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [7:0]  m_char_out_reg;
    logic        m_char_valid_reg;
    logic        m_send_valid_reg;
    logic [7:0]  m_send_byte_reg;
    logic        m_irq_reg;
    logic [31:0] m_count_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !pend_reg || out_free;
    assign accept   = s_valid && s_ready;

    urbp_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (tx_push),
        .push_data (s_char_in),
        .pop_en    (tx_pop),
        .pop_data  (tx_pop_data),
        .stat      (tx_stat)
    );

    urbp_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (rx_push),
        .push_data (s_rx_byte),
        .pop_en    (rx_pop),
        .pop_data  (rx_pop_data),
        .stat      (rx_stat)
    );

    always_comb begin
        tx_push     = 1'b0;
        tx_pop      = 1'b0;
        rx_push     = 1'b0;
        rx_pop      = 1'b0;
        bump        = '0;
        status_next = ST_OK;
        irq_next    = irq_reg;
        count_next  = '0;
        if (accept) begin
            unique case (s_operation)
                OP_PUT: begin
                    if (tx_stat.full) begin
                        bump[CNT_TX_FULL] = 1'b1;
                        status_next       = ST_TX_FULL;
                    end else begin
                        tx_push  = 1'b1;
                        irq_next = 1'b1;
                    end
                end
                OP_GET: begin
                    if (rx_stat.empty) begin
                        status_next = ST_RX_EMPTY;
                    end else begin
                        rx_pop = 1'b1;
                    end
                end
                OP_EVENT: begin
                    if (s_rx_valid) begin
                        if (rx_stat.full) begin
                            bump[CNT_RX_FULL] = 1'b1;
                        end else begin
                            rx_push = 1'b1;
                        end
                    end
                    if (s_tx_ready) begin
                        if (tx_stat.empty) begin
                            irq_next = 1'b0;
                        end else begin
                            tx_pop = 1'b1;
                        end
                    end
                    bump[CNT_HW_OVR] = s_overrun_flag;
                    bump[CNT_NOISE]  = s_noise_flag;
                    bump[CNT_FRAME]  = s_frame_flag;
                    bump[CNT_PARITY] = s_parity_flag;
                end
                OP_READ: begin
                    if (s_counter_index < 3'(NUM_COUNTS)) begin
                        count_next = 32'(cnt_reg[s_counter_index]);
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COUNTS; i++) begin
                cnt_reg[i] <= '0;
            end
            irq_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_COUNTS; i++) begin
                if (bump[i]) begin
                    cnt_reg[i] <= cnt_reg[i] + 1'b1;
                end
            end
            irq_reg <= irq_next;
            if (pend_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                pend_reg <= 1'b1;
            end else if (out_free) begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_status_reg     <= status_next;
            pend_char_valid_reg <= rx_pop;
            pend_send_valid_reg <= tx_pop;
            pend_irq_reg        <= irq_next;
            pend_count_reg      <= count_next;
        end
        if (pend_reg && out_free) begin
            m_status_reg     <= pend_status_reg;
            m_char_valid_reg <= pend_char_valid_reg;
            m_char_out_reg   <= pend_char_valid_reg ? rx_pop_data : 8'd0;
            m_send_valid_reg <= pend_send_valid_reg;
            m_send_byte_reg  <= pend_send_valid_reg ? tx_pop_data : 8'd0;
            m_irq_reg        <= pend_irq_reg;
            m_count_reg      <= pend_count_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_char_out       = m_char_out_reg;
    assign m_char_valid     = m_char_valid_reg;
    assign m_send_valid     = m_send_valid_reg;
    assign m_send_byte      = m_send_byte_reg;
    assign m_tx_irq_enabled = m_irq_reg;
    assign m_counter_value  = m_count_reg;

endmodule

`default_nettype wire

@@ hdl/urbp_checker.sv @@
// ----------------------------------------------------------------------------
// urbp_checker
// Port-level checks for the ring buffer pair, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_ring_buffer_pair_assert.svh"

module urbp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [7:0]  m_char_out,
    input wire logic        m_char_valid,
    input wire logic        m_send_valid,
    input wire logic [7:0]  m_send_byte,
    input wire logic        m_tx_irq_enabled,
    input wire logic [31:0] m_counter_value
);
    import urbp_pkg::*;

    `URBP_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_char_out) && $stable(m_send_byte))

    `URBP_ASSERT_IMPLY(a_fail_is_quiet, aclk, aresetn, m_valid && m_status != ST_OK,
        !m_char_valid && !m_send_valid && m_counter_value == 32'd0)

    `URBP_ASSERT_IMPLY(a_bytes_cleared, aclk, aresetn, m_valid,
        (m_char_valid || m_char_out == 8'd0) && (m_send_valid || m_send_byte == 8'd0))

    `URBP_ASSERT_IMPLY(a_send_needs_irq, aclk, aresetn, m_valid && m_send_valid,
        m_tx_irq_enabled)

    `URBP_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid)

endmodule

bind uart_ring_buffer_pair urbp_checker u_urbp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_char_out       (m_char_out),
    .m_char_valid     (m_char_valid),
    .m_send_valid     (m_send_valid),
    .m_send_byte      (m_send_byte),
    .m_tx_irq_enabled (m_tx_irq_enabled),
    .m_counter_value  (m_counter_value)
);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the buffered serial port against a cycle-free software model of its
// rings and error counters. Directed requests cover counter reads (including
// indexes past the last counter), empty rings, byte extremes and line error
// flags. Random bursts then fill and drain both rings past full and empty
// under several sender and receiver stall mixes. Every result is compared
// with the predicted one in request order.
// ----------------------------------------------------------------------------
module testbench;

    import urbp_pkg::*;

    localparam int TX_SLOTS = 64;
    localparam int RX_SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_in;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_ready;
        logic       overrun_flag;
        logic       noise_flag;
        logic       frame_flag;
        logic       parity_flag;
        logic [2:0] counter_index;
    } port_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  char_out;
        logic        char_valid;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        tx_irq_enabled;
        logic [31:0] counter_value;
    } port_res_t;

    typedef enum {
        SEQ_PUT_BURST, SEQ_RX_FILL, SEQ_GET_BURST, SEQ_TX_DRAIN, SEQ_READS, SEQ_NOISE
    } seq_kind_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_PUT;
    logic [7:0]  s_char_in = 8'h00;
    logic        s_rx_valid = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_tx_ready = 1'b0;
    logic        s_overrun_flag = 1'b0;
    logic        s_noise_flag = 1'b0;
    logic        s_frame_flag = 1'b0;
    logic        s_parity_flag = 1'b0;
    logic [2:0]  s_counter_index = 3'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_char_out;
    logic        m_char_valid;
    logic        m_send_valid;
    logic [7:0]  m_send_byte;
    logic        m_tx_irq_enabled;
    logic [31:0] m_counter_value;

    uart_ring_buffer_pair dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_char_in        (s_char_in),
        .s_rx_valid       (s_rx_valid),
        .s_rx_byte        (s_rx_byte),
        .s_tx_ready       (s_tx_ready),
        .s_overrun_flag   (s_overrun_flag),
        .s_noise_flag     (s_noise_flag),
        .s_frame_flag     (s_frame_flag),
        .s_parity_flag    (s_parity_flag),
        .s_counter_index  (s_counter_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_char_out       (m_char_out),
        .m_char_valid     (m_char_valid),
        .m_send_valid     (m_send_valid),
        .m_send_byte      (m_send_byte),
        .m_tx_irq_enabled (m_tx_irq_enabled),
        .m_counter_value  (m_counter_value)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // predicted port state
    logic [7:0]  tx_ring [TX_SLOTS];
    logic [7:0]  rx_ring [RX_SLOTS];
    int unsigned tx_rd, tx_wr, rx_rd, rx_wr;
    logic [31:0] fault_counts [NUM_COUNTS];
    logic        tx_irq_on;

    port_res_t awaited_results [$];
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    initial begin
        tx_rd = 0;
        tx_wr = 0;
        rx_rd = 0;
        rx_wr = 0;
        tx_irq_on = 1'b0;
        for (int i = 0; i < NUM_COUNTS; i++) fault_counts[i] = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
    end

    function automatic void bump_fault(input logic [2:0] idx);
        fault_counts[idx] = fault_counts[idx] + 32'd1;
    endfunction

    function automatic port_res_t step_serial_port(input port_req_t r);
        port_res_t res;
        int unsigned nxt;
        res = '0;
        res.status = ST_OK;
        case (r.operation)
            OP_PUT: begin
                nxt = (tx_wr + 1) % TX_SLOTS;
                if (nxt == tx_rd) begin
                    bump_fault(CNT_TX_FULL);
                    res.status = ST_TX_FULL;
                end else begin
                    tx_ring[tx_wr] = r.char_in;
                    tx_wr = nxt;
                    tx_irq_on = 1'b1;
                end
            end
            OP_GET: begin
                if (rx_rd == rx_wr) begin
                    res.status = ST_RX_EMPTY;
                end else begin
                    res.char_out = rx_ring[rx_rd];
                    res.char_valid = 1'b1;
                    rx_rd = (rx_rd + 1) % RX_SLOTS;
                end
            end
            OP_EVENT: begin
                if (r.rx_valid) begin
                    nxt = (rx_wr + 1) % RX_SLOTS;
                    if (nxt == rx_rd) begin
                        bump_fault(CNT_RX_FULL);
                    end else begin
                        rx_ring[rx_wr] = r.rx_byte;
                        rx_wr = nxt;
                    end
                end
                if (r.tx_ready) begin
                    if (tx_rd == tx_wr) begin
                        tx_irq_on = 1'b0;
                    end else begin
                        res.send_byte = tx_ring[tx_rd];
                        res.send_valid = 1'b1;
                        tx_rd = (tx_rd + 1) % TX_SLOTS;
                    end
                end
                if (r.overrun_flag) bump_fault(CNT_HW_OVR);
                if (r.noise_flag) bump_fault(CNT_NOISE);
                if (r.frame_flag) bump_fault(CNT_FRAME);
                if (r.parity_flag) bump_fault(CNT_PARITY);
            end
            default: begin
                if (r.counter_index < NUM_COUNTS) res.counter_value = fault_counts[r.counter_index];
            end
        endcase
        res.tx_irq_enabled = tx_irq_on;
        return res;
    endfunction

    always @(posedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // predict on request, check on result, watch for a hang
    always @(posedge aclk) begin : port_monitor
        port_res_t want;
        port_res_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(step_serial_port({s_operation, s_char_in,
                    s_rx_valid, s_rx_byte, s_tx_ready, s_overrun_flag, s_noise_flag,
                    s_frame_flag, s_parity_flag, s_counter_index}));
            end
            if (m_valid && m_ready) begin
                got = {m_status, m_char_out, m_char_valid, m_send_valid, m_send_byte,
                       m_tx_irq_enabled, m_counter_value};
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $write("unexpected result at %0t: status %0d char %h/%b ",
                               $realtime, got.status, got.char_out, got.char_valid);
                        $display("send %b/%h irq %b count %h", got.send_valid,
                                 got.send_byte, got.tx_irq_enabled, got.counter_value);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $write("mismatch at %0t: status %0d/%0d char %h/%h valid %b/%b ",
                                   $realtime, want.status, got.status, want.char_out,
                                   got.char_out, want.char_valid, got.char_valid);
                            $display("send %b/%b byte %h/%h irq %b/%b count %h/%h (exp/act)",
                                     want.send_valid, got.send_valid, want.send_byte,
                                     got.send_byte, want.tx_irq_enabled, got.tx_irq_enabled,
                                     want.counter_value, got.counter_value);
                        end
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    task automatic send_request(input port_req_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= r.operation;
        s_char_in <= r.char_in;
        s_rx_valid <= r.rx_valid;
        s_rx_byte <= r.rx_byte;
        s_tx_ready <= r.tx_ready;
        s_overrun_flag <= r.overrun_flag;
        s_noise_flag <= r.noise_flag;
        s_frame_flag <= r.frame_flag;
        s_parity_flag <= r.parity_flag;
        s_counter_index <= r.counter_index;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    function automatic port_req_t simple_req(input logic [1:0] op, input logic [7:0] ch,
                                             input logic [2:0] idx);
        port_req_t r;
        r = '0;
        r.operation = op;
        r.char_in = ch;
        r.counter_index = idx;
        return r;
    endfunction

    function automatic port_req_t event_req(input logic rxv, input logic [7:0] rxb,
                                            input logic txr, input logic [3:0] flags);
        port_req_t r;
        r = '0;
        r.operation = OP_EVENT;
        r.rx_valid = rxv;
        r.rx_byte = rxb;
        r.tx_ready = txr;
        {r.overrun_flag, r.noise_flag, r.frame_flag, r.parity_flag} = flags;
        return r;
    endfunction

    function automatic port_req_t rand_request();
        logic [31:0] bits;
        bits = $urandom;
        return bits[$bits(port_req_t)-1:0];
    endfunction

    task automatic test_counters_after_reset();
        for (int i = 0; i < 8; i++) send_request(simple_req(OP_READ, 8'h00, 3'(i)));
    endtask

    task automatic test_empty_rings();
        send_request(simple_req(OP_GET, 8'h00, CNT_HW_OVR));
        send_request(event_req(1'b0, 8'h00, 1'b1, 4'b0000));
    endtask

    task automatic test_byte_extremes();
        send_request(simple_req(OP_PUT, 8'h00, CNT_HW_OVR));
        send_request(simple_req(OP_PUT, 8'hFF, CNT_HW_OVR));
        send_request(event_req(1'b1, 8'h00, 1'b1, 4'b0000));
        send_request(event_req(1'b1, 8'hFF, 1'b1, 4'b0000));
        send_request(event_req(1'b0, 8'h00, 1'b1, 4'b0000));
        send_request(simple_req(OP_GET, 8'h00, CNT_HW_OVR));
        send_request(simple_req(OP_GET, 8'h00, CNT_HW_OVR));
        send_request(simple_req(OP_GET, 8'h00, CNT_HW_OVR));
    endtask

    task automatic test_error_flags();
        send_request(event_req(1'b0, 8'h00, 1'b0, 4'b1111));
        send_request(event_req(1'b0, 8'h00, 1'b0, 4'b1000));
        send_request(simple_req(OP_READ, 8'h00, CNT_HW_OVR));
        send_request(simple_req(OP_READ, 8'h00, CNT_NOISE));
        send_request(simple_req(OP_READ, 8'h00, CNT_FRAME));
        send_request(simple_req(OP_READ, 8'h00, CNT_PARITY));
    endtask

    // bursts long enough to run either ring past full and back past empty
    task automatic test_random_traffic(input int unsigned item_total);
        int unsigned sent;
        int unsigned burst;
        seq_kind_t kind;
        port_req_t r;
        sent = 0;
        while (sent < item_total) begin
            kind = seq_kind_t'($urandom_range(0, 5));
            burst = (kind == SEQ_READS || kind == SEQ_NOISE) ? $urandom_range(1, 8)
                                                              : $urandom_range(1, 80);
            repeat (burst) begin
                r = rand_request();
                case (kind)
                    SEQ_PUT_BURST: r.operation = OP_PUT;
                    SEQ_RX_FILL: begin
                        r.operation = OP_EVENT;
                        r.rx_valid = 1'b1;
                        r.tx_ready = ($urandom_range(0, 7) == 0);
                    end
                    SEQ_GET_BURST: r.operation = OP_GET;
                    SEQ_TX_DRAIN: begin
                        r.operation = OP_EVENT;
                        r.tx_ready = 1'b1;
                        r.rx_valid = ($urandom_range(0, 7) == 0);
                    end
                    SEQ_READS: r.operation = OP_READ;
                    default: ;
                endcase
                send_request(r);
                sent++;
            end
            if ($urandom_range(0, 19) == 0) hold_until_drained();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_counters_after_reset();
        test_empty_rings();
        test_byte_extremes();
        test_error_flags();

        test_random_traffic(175);
        hold_until_drained();
        send_idle_pct = 87;
        test_random_traffic(175);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        test_random_traffic(175);
        hold_until_drained();
        send_idle_pct = 26;
        recv_stall_pct = 26;
        test_random_traffic(175);

        hold_until_drained();
        repeat (8) @(posedge aclk);
        mismatch_count += awaited_results.size();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
